/* rtl/core/gr_pkg.sv */
// Shared types and constants for the grid ray wall caster.
// Used by every module in rtl/core; depends on nothing.
package gr_pkg;

	// Field widths
	localparam int POS_W  = 15;
	localparam int ANG_W  = 12;
	localparam int DIST_W = 16;
	localparam int HGT_W  = 10;
	localparam int TOP_W  = 9;
	localparam int IN_W   = 56;
	localparam int OUT_W  = 72;

	// Grid geometry: a cell is 4096 in Q6, an 8 x 8 grid spans 32768
	localparam int CELL_SH = 12;
	localparam int GRID_N  = 8;

	// Serial unit widths
	localparam int DIV_W  = 34;
	localparam int DVS_W  = 17;
	localparam int SQ_W   = 31;
	localparam int ROOT_W = 16;
	localparam int TRIG_W = 18;

	// Sine polynomial coefficients, Q16
	localparam logic [16:0] SIN_C0 = 17'd102944;
	localparam logic [16:0] SIN_C1 = 17'd42334;
	localparam logic [16:0] SIN_C2 = 17'd5223;
	localparam logic [16:0] SIN_C3 = 17'd307;
	localparam logic [16:0] SIN_ONE = 17'd65536;

	// Configuration register indexes
	localparam logic REG_WALL   = 1'b0;
	localparam logic REG_SCREEN = 1'b1;
	localparam logic [9:0] SCREEN_RST = 10'd320;

	// Trig slots
	localparam logic [1:0] TSEL_SIN  = 2'd0;
	localparam logic [1:0] TSEL_COS  = 2'd1;
	localparam logic [1:0] TSEL_VIEW = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_TRIG,
		OP_TRIG_SAVE,
		OP_AXIS,
		OP_NEXTK,
		OP_MUL,
		OP_DIV,
		OP_STEP,
		OP_SQ1,
		OP_SQ2,
		OP_SQRT,
		OP_CORR,
		OP_HDIV,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic trig_done;
		logic div_done;
		logic sqrt_done;
		logic axis_skip;
		logic line_skip;
		logic k_last;
		logic hit;
		logic any_hit;
		logic corr_zero;
		logic out_free;
	} stat_t;

endpackage

/* rtl/core/gr_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on gr_pkg for its widths.
module gr_div import gr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   trial_sub;
	logic             ge;

	// Trial subtract of the divisor from the shifted remainder
	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* rtl/core/gr_sqrt.sv */
// Integer square root, one result bit per cycle.
// Depends on gr_pkg for its widths.
module gr_sqrt import gr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   val,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [3:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W:0]   sum;
	logic            ge;

	assign sum = {1'b0, res_q} + {1'b0, bit_q};
	assign ge  = {1'b0, v_q} >= sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One bit pair of the radicand per cycle, from the top power of four down
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= val;
			res_q <= '0;
			bit_q <= {1'b1, {(SQ_W-1){1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				v_q   <= v_q - sum[SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

/* rtl/core/gr_trig.sv */
// Sine of a 12-bit binary angle in signed Q16, from a quarter-wave
// odd polynomial evaluated over five multiply steps. Depends on gr_pkg.
module gr_trig import gr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ANG_W-1:0]         angle,
	output logic                     done,
	output logic signed [TRIG_W-1:0] value
);

	logic [2:0]  st_q;
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [15:0] t_q;
	logic [15:0] t2_q;
	logic [16:0] p_q;
	logic signed [TRIG_W-1:0] val_q;
	logic [10:0] rr;
	logic [15:0] ma;
	logic [16:0] mb;
	logic [32:0] prod;
	logic [16:0] ph;
	logic [16:0] s;

	// Fold the angle into the first quarter
	assign rr = angle[10] ? (11'd1024 - {1'b0, angle[9:0]}) : {1'b0, angle[9:0]};

	// Shared multiplier
	always_comb begin
		ma = (st_q == 3'd0 || st_q == 3'd4) ? t_q : t2_q;
		case (st_q)
			3'd0:    mb = {1'b0, t_q};
			3'd1:    mb = SIN_C3;
			default: mb = p_q;
		endcase
		prod = ma * mb;
		ph   = prod[32:16];
		s    = (ph > SIN_ONE) ? SIN_ONE : ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			st_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				st_q <= '0;
				if (rr[10]) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				st_q <= st_q + 3'd1;
				if (st_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Horner steps of the polynomial
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= angle[11];
			t_q   <= {rr[9:0], 6'd0};
			if (rr[10]) begin
				val_q <= angle[11] ? -$signed({1'b0, SIN_ONE}) : $signed({1'b0, SIN_ONE});
			end
		end else if (busy_q) begin
			case (st_q)
				3'd0:    t2_q <= ph[15:0];
				3'd1:    p_q  <= SIN_C2 - ph;
				3'd2:    p_q  <= SIN_C1 - ph;
				3'd3:    p_q  <= SIN_C0 - ph;
				default: val_q <= neg_q ? -$signed({1'b0, s}) : $signed({1'b0, s});
			endcase
		end
	end

	assign done  = done_q;
	assign value = val_q;

endmodule

/* rtl/core/gr_dp.sv */
// Datapath of the ray caster: item and register storage, line search
// arithmetic, distance, correction and result register. Uses gr_pkg,
// gr_trig, gr_div and gr_sqrt.
module gr_dp import gr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [IN_W-1:0]  in_data,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [63:0]      cfg_data,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	logic [POS_W-1:0] px_q, py_q;
	logic [ANG_W-1:0] view_q, ray_q;
	logic signed [TRIG_W-1:0] sn_q, cs_q, cv_q;
	logic             ax_q;
	logic [2:0]       k_q;
	logic [1:0]       found_q;
	logic [POS_W-1:0] line_q [2];
	logic [POS_W-1:0] b_q [2];
	logic [SQ_W-1:0]  d_q [2];
	logic [DIV_W-1:0] prod_q;
	logic             prod_neg_q;
	logic [29:0]      sq_q;
	logic [DIST_W-1:0] corr_q;
	logic [63:0]      wall_q;
	logic [9:0]       scr_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [ANG_W-1:0] trig_ang;
	logic             trig_done;
	logic signed [TRIG_W-1:0] trig_val;
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dvd, quot;
	logic [DVS_W-1:0] div_dvs;
	logic             sqrt_done;
	logic [ROOT_W-1:0] root;

	logic [POS_W-1:0] own, other;
	logic             neg, axis_skip;
	logic signed [TRIG_W-1:0] num, den;
	logic [16:0]      first, kx;
	logic signed [18:0] line_s, diff;
	logic [18:0]      diff_mag;
	logic [TRIG_W-1:0] num_mag, den_mag;
	logic [4:0]       ac_full;
	logic             line_skip;
	logic signed [35:0] q_s, b_s;
	logic             b_off;
	logic [5:0]       idx;
	logic             hit;
	logic signed [15:0] dl, db;
	logic [14:0]      dl_mag, db_mag;
	logic             any_hit, use_h;
	logic [32:0]      cprod;
	logic [9:0]       height;
	logic [9:0]       hgap;

	// Search set-up for the current axis: horizontal lines step y, vertical step x
	always_comb begin
		own       = ax_q ? px_q : py_q;
		other     = ax_q ? py_q : px_q;
		neg       = ax_q ? (ray_q > 12'd1024 && ray_q < 12'd3072) : (ray_q > 12'd2048);
		num       = ax_q ? sn_q : cs_q;
		den       = ax_q ? cs_q : sn_q;
		axis_skip = ax_q ? (ray_q == 12'd1024 || ray_q == 12'd3072)
		                 : (ray_q == 12'd0 || ray_q == 12'd2048);
		first     = {2'b00, own[14:CELL_SH], {CELL_SH{1'b0}}} + (neg ? 17'd0 : 17'd4096);
		kx        = {2'b00, k_q, {CELL_SH{1'b0}}};
		line_s    = neg ? ($signed({2'b00, first}) - $signed({2'b00, kx}))
		                : ($signed({2'b00, first}) + $signed({2'b00, kx}));
		ac_full   = neg ? (line_s[16:12] - 5'd1) : line_s[16:12];
		line_skip = (neg && line_s < 19'sd4096) || (ac_full >= 5'(GRID_N));
		diff      = line_s - $signed({4'b0000, own});
		diff_mag  = diff[18] ? 19'(-diff) : 19'(diff);
		num_mag   = num[TRIG_W-1] ? TRIG_W'(-num) : TRIG_W'(num);
		den_mag   = den[TRIG_W-1] ? TRIG_W'(-den) : TRIG_W'(den);
	end

	// Crossing on the other axis and its wall bit
	always_comb begin
		q_s   = prod_neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
		b_s   = $signed({21'd0, other}) + q_s;
		b_off = b_s[35] || (b_s[34:15] != 20'd0);
		idx   = ax_q ? {b_s[14:12], ac_full[2:0]} : {ac_full[2:0], b_s[14:12]};
		hit   = !b_off && wall_q[idx];
	end

	// Offsets from the player to the stored hit
	always_comb begin
		dl     = $signed({1'b0, line_q[ax_q]}) - $signed({1'b0, own});
		db     = $signed({1'b0, b_q[ax_q]}) - $signed({1'b0, other});
		dl_mag = dl[15] ? 15'(-dl) : 15'(dl);
		db_mag = db[15] ? 15'(-db) : 15'(db);
	end

	assign any_hit = found_q[0] | found_q[1];
	assign use_h   = found_q[0] && (!found_q[1] || d_q[0] < d_q[1]);
	assign cprod   = root * cv_q[16:0];

	// Height clamp against the screen height
	always_comb begin
		if (corr_q == '0) begin
			height = scr_q;
		end else if (quot > {24'd0, scr_q}) begin
			height = scr_q;
		end else begin
			height = quot[9:0];
		end
		hgap = scr_q - height;
	end

	// Trig unit angle choice
	always_comb begin
		case (cmd.sel)
			TSEL_SIN: trig_ang = ray_q;
			TSEL_COS: trig_ang = ray_q + 12'd1024;
			default:  trig_ang = view_q - ray_q + 12'd1024;
		endcase
	end

	assign div_start = (cmd.op == OP_DIV) || (cmd.op == OP_HDIV);
	assign div_dvd   = (cmd.op == OP_HDIV) ? {12'd0, scr_q, 12'd0} : prod_q;
	assign div_dvs   = (cmd.op == OP_HDIV) ? {1'b0, corr_q} : den_mag[DVS_W-1:0];

	gr_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_TRIG),
		.angle  (trig_ang),
		.done   (trig_done),
		.value  (trig_val)
	);

	gr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (quot)
	);

	gr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT),
		.val    (use_h ? d_q[0] : d_q[1]),
		.done   (sqrt_done),
		.root   (root)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_q <= '0;
			scr_q  <= SCREEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WALL:   wall_q <= cfg_data;
				REG_SCREEN: scr_q  <= cfg_data[9:0];
				default:    wall_q <= wall_q;
			endcase
		end
	end

	// Search control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q    <= 1'b0;
			k_q     <= '0;
			found_q <= '0;
		end else begin
			case (cmd.op)
				OP_AXIS: begin
					ax_q             <= cmd.sel[0];
					k_q              <= '0;
					found_q[cmd.sel[0]] <= 1'b0;
				end
				OP_NEXTK: k_q <= k_q + 3'd1;
				OP_STEP: begin
					if (hit) begin
						found_q[ax_q] <= 1'b1;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= in_data[14:0];
			py_q   <= in_data[29:15];
			view_q <= in_data[41:30];
			ray_q  <= in_data[53:42];
		end
		case (cmd.op)
			OP_TRIG_SAVE: begin
				case (cmd.sel)
					TSEL_SIN: sn_q <= trig_val;
					TSEL_COS: cs_q <= trig_val;
					default:  cv_q <= trig_val;
				endcase
			end
			OP_MUL: begin
				prod_q     <= {17'd0, diff_mag[16:0]} * {17'd0, num_mag[16:0]};
				prod_neg_q <= diff[18] ^ num[TRIG_W-1] ^ den[TRIG_W-1];
			end
			OP_STEP: begin
				if (hit) begin
					line_q[ax_q] <= line_s[14:0];
					b_q[ax_q]    <= b_s[14:0];
				end
			end
			OP_SQ1: sq_q <= dl_mag * dl_mag;
			OP_SQ2: d_q[ax_q] <= {1'b0, sq_q} + {16'd0, db_mag} * {16'd0, db_mag};
			OP_CORR: begin
				if (cv_q[TRIG_W-1] || cv_q == '0) begin
					corr_q <= '0;
				end else if (cprod[32]) begin
					corr_q <= '1;
				end else begin
					corr_q <= cprod[31:16];
				end
			end
			default: sq_q <= sq_q;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			if (!any_hit) begin
				m_tdata_q <= {5'd0, scr_q[9:1], 10'd0, 16'hFFFF, 1'b0, 1'b0, py_q, px_q};
			end else begin
				m_tdata_q <= {5'd0, hgap[9:1], height, corr_q, use_h, 1'b1,
				              use_h ? line_q[0] : b_q[1],
				              use_h ? b_q[0] : line_q[1]};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.trig_done = trig_done;
	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.axis_skip = axis_skip;
	assign stat.line_skip = line_skip;
	assign stat.k_last    = (k_q == 3'(GRID_N - 1));
	assign stat.hit       = hit;
	assign stat.any_hit   = any_hit;
	assign stat.corr_zero = (corr_q == '0);
	assign stat.out_free  = !m_tvalid_q || m_tready;

endmodule

/* rtl/core/gr_ctrl.sv */
// Sequencer of the ray caster: walks trig, both line searches, distance,
// correction and height steps, issuing commands to gr_dp. Uses gr_pkg.
module gr_ctrl import gr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  idle
);

	typedef enum logic [3:0] {
		S_IDLE, S_TRIG, S_TWAIT, S_AXIS, S_LINE, S_DIV, S_DWAIT,
		S_SQ1, S_SQ2, S_SQRT, S_SWAIT, S_CORR, S_HDIV, S_HWAIT, S_OUT
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;

	// Next state and command
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd.op  = OP_NOP;
		cmd.sel = sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_TRIG;
					sel_d   = TSEL_SIN;
				end
			end
			S_TRIG: begin
				cmd.op  = OP_TRIG;
				state_d = S_TWAIT;
			end
			S_TWAIT: begin
				if (stat.trig_done) begin
					cmd.op = OP_TRIG_SAVE;
					if (sel_q == TSEL_VIEW) begin
						sel_d   = 2'd0;
						state_d = S_AXIS;
					end else begin
						sel_d   = sel_q + 2'd1;
						state_d = S_TRIG;
					end
				end
			end
			S_AXIS: begin
				cmd.op  = OP_AXIS;
				state_d = S_LINE;
			end
			S_LINE: begin
				if (stat.axis_skip || (stat.line_skip && stat.k_last)) begin
					cmd.op  = stat.axis_skip ? OP_NOP : OP_NEXTK;
					sel_d   = 2'd1;
					state_d = sel_q[0] ? S_SQRT : S_AXIS;
				end else if (stat.line_skip) begin
					cmd.op = OP_NEXTK;
				end else begin
					cmd.op  = OP_MUL;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op  = OP_DIV;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_STEP;
					if (stat.hit) begin
						state_d = S_SQ1;
					end else if (stat.k_last) begin
						sel_d   = 2'd1;
						state_d = sel_q[0] ? S_SQRT : S_AXIS;
					end else begin
						state_d = S_LINE;
					end
				end
			end
			S_SQ1: begin
				cmd.op  = OP_SQ1;
				state_d = S_SQ2;
			end
			S_SQ2: begin
				cmd.op  = OP_SQ2;
				sel_d   = 2'd1;
				state_d = sel_q[0] ? S_SQRT : S_AXIS;
			end
			S_SQRT: begin
				if (stat.any_hit) begin
					cmd.op  = OP_SQRT;
					state_d = S_SWAIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_SWAIT: begin
				if (stat.sqrt_done) begin
					state_d = S_CORR;
				end
			end
			S_CORR: begin
				cmd.op  = OP_CORR;
				state_d = S_HDIV;
			end
			S_HDIV: begin
				if (stat.corr_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_HDIV;
					state_d = S_HWAIT;
				end
			end
			S_HWAIT: begin
				if (stat.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and slot selector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign idle = (state_q == S_IDLE);

endmodule

/* rtl/core/grid_ray_wall_cast.sv */
// Grid ray caster: casts one ray per transfer over an 8 x 8 wall bitmap and
// returns the nearer wall hit, its side, the fisheye-corrected distance and
// the projected wall height with its top offset. One ray is in flight at a
// time. The time per ray is set mostly by the serial divider, which runs
// for each grid line crossing that is tested (up to 16 per ray) and for
// the height division, and also by the three sine evaluations and the
// square root. A finished result waits in the output register while the
// next ray is taken in. Uses gr_pkg, gr_ctrl and gr_dp.
module grid_ray_wall_cast import gr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // pos_x, pos_y, view_angle, ray_angle
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // hit_x, hit_y, hit_found, hit_side,
	                                    // wall_distance, wall_height, wall_top
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [63:0]      cfg_data
);

	cmd_t  cmd;
	stat_t stat;
	logic  idle;
	logic  in_fire;

	assign s_tready = idle;
	assign in_fire  = s_tvalid & idle;

	gr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.stat    (stat),
		.cmd     (cmd),
		.idle    (idle)
	);

	gr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* rtl/core/gr_checker.sv */
// Port-level checks for grid_ray_wall_cast, attached by bind.
// Uses gr_pkg for port widths.
module gr_checker import gr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// One ray at a time: an accepted transfer closes the input
	a_one_ray: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a ray is in flight");

	// A miss reports saturated distance, no height and the light side
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[30] |->
			m_tdata[47:32] == 16'hFFFF && m_tdata[57:48] == 10'd0 && !m_tdata[31])
		else $error("miss result fields inconsistent");

	// Padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:67] == 5'd0)
		else $error("result padding not zero");

endmodule

bind grid_ray_wall_cast gr_checker u_gr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* dv/grid_ray_wall_cast_test.sv */
// Self-checking testbench for grid_ray_wall_cast: random and directed rays over several
// wall maps and screen heights, checked field by field against an in-bench predictor.
// Depends on gr_pkg and the grid_ray_wall_cast RTL only.
`timescale 1ns / 1ps

module grid_ray_wall_cast_test;
	import gr_pkg::*;

	localparam longint CELL_Q = 4096;
	localparam longint GRID_SPAN = 8 * 4096;
	localparam int SETTLE_CYCLES = 1000;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [14:0] px;
		logic [14:0] py;
		logic [11:0] view;
		logic [11:0] ray;
	} ray_t;

	typedef struct {
		logic [14:0] hit_x;
		logic [14:0] hit_y;
		logic        found;
		logic        side;
		logic [15:0] wall_dist;
		logic [9:0]  height;
		logic [8:0]  top;
	} hit_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we;
	logic cfg_index;
	logic [63:0] cfg_data;

	// Predictor's copy of the registers
	logic [63:0] walls;
	logic [9:0]  scr_h;

	ray_t rays_pending[$];
	hit_t hits_expected[$];
	int errors;
	int rays_sent;
	int hits_seen;
	int hits_found;
	longint cycles;
	bit src_burst;
	bit snk_burst;
	int src_gap;

	grid_ray_wall_cast dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Quarter-wave sine, Q16
	function automatic longint quarter_sine(int r);
		longint t, t2, p, s;
		if (r >= 1024) return 65536;
		t = r * 64;
		t2 = (t * t) >>> 16;
		p = 307;
		p = 5223 - ((t2 * p) >>> 16);
		p = 42334 - ((t2 * p) >>> 16);
		p = 102944 - ((t2 * p) >>> 16);
		s = (t * p) >>> 16;
		if (s > 65536) s = 65536;
		return s;
	endfunction

	function automatic longint sine(logic [11:0] a);
		int r;
		r = a[9:0];
		case (a[11:10])
			2'd0: return quarter_sine(r);
			2'd1: return quarter_sine(1024 - r);
			2'd2: return -quarter_sine(r);
			default: return -quarter_sine(1024 - r);
		endcase
	endfunction

	function automatic longint cosine(logic [11:0] a);
		logic [11:0] b;
		b = a + 12'd1024;
		return sine(b);
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res, bitv;
		res = 0;
		bitv = 64'sd1 <<< 62;
		while (bitv > v) bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	// Walk up to eight grid lines along one axis; report the first wall crossing
	function automatic bit walk_lines(longint own, longint other, bit neg, longint num,
			longint den, bit horiz, output longint hl, output longint ho);
		longint first, ln, ac, bc, b;
		int idx;
		hl = 0;
		ho = 0;
		first = (own / CELL_Q) * CELL_Q + (neg ? 0 : CELL_Q);
		for (int k = 0; k < 8; k++) begin
			ln = neg ? first - k * CELL_Q : first + k * CELL_Q;
			if (neg) begin
				if (ln < CELL_Q) continue;
				ac = ln / CELL_Q - 1;
			end else begin
				ac = ln / CELL_Q;
			end
			if (ac >= 8) continue;
			b = other + (ln - own) * num / den;
			if (b < 0 || b >= GRID_SPAN) continue;
			bc = b / CELL_Q;
			idx = horiz ? int'(ac * 8 + bc) : int'(bc * 8 + ac);
			if (walls[idx & 63]) begin
				hl = ln;
				ho = b;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic hit_t cast_ray(ray_t r);
		hit_t o;
		longint px, py, sn, cs, hl, ho, vl, vo, dh, dv, raw_len, c, corr, hgt, h;
		bit hh, vh, use_h;
		px = r.px;
		py = r.py;
		sn = sine(r.ray);
		cs = cosine(r.ray);
		h = scr_h;
		hh = 0;
		vh = 0;
		dh = 0;
		dv = 0;
		if (r.ray != 12'd0 && r.ray != 12'd2048)
			hh = walk_lines(py, px, r.ray > 12'd2048, cs, sn, 1'b1, hl, ho);
		if (r.ray != 12'd1024 && r.ray != 12'd3072)
			vh = walk_lines(px, py, r.ray > 12'd1024 && r.ray < 12'd3072, sn, cs, 1'b0,
				vl, vo);
		if (hh) dh = (hl - py) * (hl - py) + (ho - px) * (ho - px);
		if (vh) dv = (vl - px) * (vl - px) + (vo - py) * (vo - py);
		use_h = hh && (!vh || dh < dv);
		o.found = hh || vh;
		o.side = use_h;
		if (!o.found) begin
			o.hit_x = r.px;
			o.hit_y = r.py;
			o.wall_dist = 16'hFFFF;
			o.height = 0;
			o.top = h / 2;
			return o;
		end
		if (use_h) begin
			o.hit_x = ho[14:0];
			o.hit_y = hl[14:0];
			raw_len = int_sqrt(dh);
		end else begin
			o.hit_x = vl[14:0];
			o.hit_y = vo[14:0];
			raw_len = int_sqrt(dv);
		end
		c = cosine(r.view - r.ray);
		corr = (c <= 0) ? 0 : ((raw_len * c) >>> 16);
		if (corr > 65535) corr = 65535;
		hgt = (corr == 0) ? h : (CELL_Q * h) / corr;
		if (hgt > h) hgt = h;
		o.wall_dist = corr[15:0];
		o.height = hgt[9:0];
		o.top = (h - hgt) / 2;
		return o;
	endfunction

	function automatic int pick_gap(bit burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Clock, reset and run limit
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run limit reached, %0d results outstanding", $realtime,
				hits_expected.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Source side: present pending rays, predict on each transfer
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		ray_t cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap = 0;
		end else begin
			nv = s_tvalid;
			if ($urandom_range(0, 199) == 0) src_burst = ~src_burst;
			if (s_tvalid && s_tready) begin
				hits_expected.push_back(cast_ray(rays_pending.pop_front()));
				rays_sent++;
				nv = 1'b0;
				src_gap = pick_gap(src_burst);
			end
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (rays_pending.size() > 0) begin
					cur = rays_pending[0];
					nv = 1'b1;
					s_tdata <= {2'b00, cur.ray, cur.view, cur.py, cur.px};
				end
			end
			s_tvalid <= nv;
		end
	end

	// Sink side: random back-pressure, compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		hit_t e, a;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) snk_burst = ~snk_burst;
			m_tready <= (pick_gap(snk_burst) == 0);
			if (m_tvalid && m_tready) begin
				a.hit_x = m_tdata[14:0];
				a.hit_y = m_tdata[29:15];
				a.found = m_tdata[30];
				a.side = m_tdata[31];
				a.wall_dist = m_tdata[47:32];
				a.height = m_tdata[57:48];
				a.top = m_tdata[66:58];
				hits_seen++;
				if (hits_expected.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, m_tdata);
					errors++;
				end else begin
					e = hits_expected.pop_front();
					if (a.found) hits_found++;
					if (a.hit_x !== e.hit_x) begin
						$display("%0t: hit_x exp %0d got %0d", $realtime, e.hit_x, a.hit_x);
						errors++;
					end
					if (a.hit_y !== e.hit_y) begin
						$display("%0t: hit_y exp %0d got %0d", $realtime, e.hit_y, a.hit_y);
						errors++;
					end
					if (a.found !== e.found) begin
						$display("%0t: hit_found exp %0d got %0d", $realtime, e.found,
							a.found);
						errors++;
					end
					if (a.side !== e.side) begin
						$display("%0t: hit_side exp %0d got %0d", $realtime, e.side, a.side);
						errors++;
					end
					if (a.wall_dist !== e.wall_dist) begin
						$display("%0t: wall_distance exp %0d got %0d", $realtime,
							e.wall_dist, a.wall_dist);
						errors++;
					end
					if (a.height !== e.height) begin
						$display("%0t: wall_height exp %0d got %0d", $realtime, e.height,
							a.height);
						errors++;
					end
					if (a.top !== e.top) begin
						$display("%0t: wall_top exp %0d got %0d", $realtime, e.top, a.top);
						errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(logic idx, logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == REG_WALL) walls = v;
		else scr_h = v[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for the block to finish everything in flight
	task automatic drain();
		while (rays_pending.size() > 0 || hits_expected.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_ray(int px, int py, int view, int ray);
		ray_t r;
		r.px = px;
		r.py = py;
		r.view = view;
		r.ray = ray;
		rays_pending.push_back(r);
	endtask

	function automatic int rand_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return $urandom_range(0, 32767);
		if (r < 8) return ($urandom_range(0, 7) * 4096 + $urandom_range(0, 6)) & 32767;
		return ($urandom_range(1, 7) * 4096 - $urandom_range(0, 2)) & 32767;
	endfunction

	function automatic int rand_angle();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) return $urandom_range(0, 4095);
		if (r < 17) return $urandom_range(0, 3) * 1024;
		return ($urandom_range(0, 3) * 1024 + $urandom_range(0, 1) * 2 - 1) & 4095;
	endfunction

	task automatic add_random(int n);
		int ray;
		for (int i = 0; i < n; i++) begin
			ray = rand_angle();
			add_ray(rand_pos(), rand_pos(),
				($urandom_range(0, 9) < 6) ? ((ray + $urandom_range(0, 1400) - 700) & 4095)
				: $urandom_range(0, 4095), ray);
		end
	endtask

	// Stimulus: a series of maps and screen heights
	initial begin
		cfg_we <= 1'b0;
		cfg_index <= REG_WALL;
		cfg_data <= '0;
		walls = 64'd0;
		scr_h = 10'd320;
		errors = 0;
		rays_sent = 0;
		hits_seen = 0;
		hits_found = 0;
		cycles = 0;
		src_burst = 0;
		snk_burst = 0;
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// Empty map after reset: every ray misses
		add_ray(16384, 16384, 0, 0);
		add_ray(0, 32767, 4095, 4095);
		add_random(40);
		drain();

		// Border walls on a tall screen: directed corner cases first
		write_reg(REG_WALL, 64'hFF81_8181_8181_81FF);
		write_reg(REG_SCREEN, 10'd1023);
		add_ray(16384, 16384, 0, 0);
		add_ray(16384, 16384, 1024, 1024);
		add_ray(16384, 16384, 2048, 2048);
		add_ray(16384, 16384, 3072, 3072);
		add_ray(0, 0, 512, 512);
		add_ray(32767, 32767, 2560, 2560);
		add_ray(32767, 0, 3584, 3584);
		add_ray(0, 32767, 1536, 1536);
		add_ray(8192, 8192, 2560, 2560);       // start on a line heading down
		add_ray(12288, 20000, 2048, 2048);     // on a vertical line heading left
		add_ray(20000, 20000, 0, 2048);        // facing away
		add_ray(20000, 20000, 1024, 0);        // right angle to the view
		add_ray(16384, 16384, 512, 512);       // exact diagonal: tie between the searches
		add_ray(5000, 9000, 1, 1);
		add_ray(5000, 9000, 1023, 1023);
		add_ray(5000, 9000, 1025, 1025);
		add_ray(5000, 9000, 4095, 4095);
		add_ray(4100, 4100, 2047, 2049);
		add_ray(28000, 4100, 3071, 3073);
		add_ray(4096, 4096, 100, 3000);
		add_random(70);
		drain();

		// Random map, smallest screen
		write_reg(REG_WALL, {$urandom, $urandom});
		write_reg(REG_SCREEN, 10'd1);
		add_random(70);
		drain();

		// Every cell a wall
		write_reg(REG_WALL, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SCREEN, 10'd480);
		add_random(60);
		drain();

		// Sparse random maps at random heights
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_WALL, {$urandom, $urandom} & {$urandom, $urandom});
			write_reg(REG_SCREEN, $urandom_range(1, 1023));
			add_random(40);
			drain();
		end

		$display("Cast %0d rays over 7 wall maps and screen heights 1 to 1023;", rays_sent);
		$display("%0d results checked, %0d of them wall hits, %0d mismatches.", hits_seen,
			hits_found, errors);
		if (errors == 0 && hits_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* grid_ray_wall_cast.f */
rtl/core/gr_pkg.sv
rtl/core/gr_div.sv
rtl/core/gr_sqrt.sv
rtl/core/gr_trig.sv
rtl/core/gr_dp.sv
rtl/core/gr_ctrl.sv
rtl/core/grid_ray_wall_cast.sv
rtl/core/gr_checker.sv
dv/grid_ray_wall_cast_test.sv
